// ===== hdl/bezier6_pos_vel_acc_eval_assert.svh =====
// Assertion macros used by the RTL.
`ifndef BEZIER6_POS_VEL_ACC_EVAL_ASSERT_SVH
`define BEZIER6_POS_VEL_ACC_EVAL_ASSERT_SVH

// Assert that a condition implies a property in the same cycle.
`define BZ_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Assert that a condition implies a property in the next cycle.
`define BZ_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ===== hdl/bz6_pkg.sv =====
package bz6_pkg;

    localparam int unsigned DataW = 32;
    localparam int unsigned DurW  = 16;
    localparam int unsigned TimeW = 17;
    localparam int unsigned FracW = 16;
    // Wide internal value: holds second differences and all lerp outputs.
    localparam int unsigned ValW  = 36;
    localparam int unsigned NumPts = 7;
    // Quotient width and divider chain depth, used by the top level and its assertions.
    localparam int unsigned QuoW  = 52;
    localparam int unsigned DivStages = QuoW;

    typedef logic signed [ValW-1:0] t_val;
    typedef logic [TimeW-1:0]       t_time;

    // One de Casteljau step: a + round_half_up((b-a)*t / 2^16).
    function automatic t_val lerp(input t_val a, input t_val b, input t_time t);
        logic signed [ValW:0]      diff;
        logic signed [ValW+TimeW+1:0] prod;
        logic signed [ValW+TimeW+1:0] rnd;
        begin
            diff = {a[ValW-1], a} - {b[ValW-1], b};
            diff = -diff;
            prod = diff * $signed({1'b0, t});
            rnd  = prod + (ValW+TimeW+2)'(1 << (FracW - 1));
            lerp = a + t_val'(rnd >>> FracW);
        end
    endfunction

endpackage

// ===== hdl/bezier6_pos_vel_acc_eval.sv =====
// Throughput: one item per cycle while not stalled; three chains of de Casteljau
// cells and a chain of one-bit divider cells each take a new item in every cycle.
// The whole pipeline advances only when its final stage is empty or being taken.
// Reset clears all stage valid bits; data registers are not reset.
module bezier6_pos_vel_acc_eval (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [bz6_pkg::DataW-1:0] i_ctrl_point_0,
    input  logic signed [bz6_pkg::DataW-1:0] i_ctrl_point_1,
    input  logic signed [bz6_pkg::DataW-1:0] i_ctrl_point_2,
    input  logic signed [bz6_pkg::DataW-1:0] i_ctrl_point_3,
    input  logic signed [bz6_pkg::DataW-1:0] i_ctrl_point_4,
    input  logic signed [bz6_pkg::DataW-1:0] i_ctrl_point_5,
    input  logic signed [bz6_pkg::DataW-1:0] i_ctrl_point_6,
    input  logic [bz6_pkg::DurW-1:0]  i_seg_duration,
    input  logic [bz6_pkg::TimeW-1:0] i_t_norm,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [bz6_pkg::DataW-1:0] o_position,
    output logic signed [bz6_pkg::DataW-1:0] o_velocity,
    output logic signed [bz6_pkg::DataW-1:0] o_acceleration,
    output logic                 o_saturated
);
    import bz6_pkg::*;
    `include "bezier6_pos_vel_acc_eval_assert.svh"

    localparam int unsigned Lvl = NumPts - 1;
    localparam int unsigned Lat = Lvl + 3 + DivStages;

    logic en;
    logic [Lat-1:0] r_vld;

    // Single stall: everything moves when the output slot is free.
    assign en      = !r_vld[Lat-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[Lat-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[Lat-2:0], i_valid};
        end
    end

    // Stage 0: capture, clamp time, form differences.
    t_val  r_p [7];
    t_val  r_d1 [6];
    t_val  r_d2 [5];
    t_time r_t0;
    logic [DurW-1:0] r_dur [Lvl+2];
    t_val  p_in [7];

    assign p_in[0] = t_val'(i_ctrl_point_0);
    assign p_in[1] = t_val'(i_ctrl_point_1);
    assign p_in[2] = t_val'(i_ctrl_point_2);
    assign p_in[3] = t_val'(i_ctrl_point_3);
    assign p_in[4] = t_val'(i_ctrl_point_4);
    assign p_in[5] = t_val'(i_ctrl_point_5);
    assign p_in[6] = t_val'(i_ctrl_point_6);

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 7; i++) r_p[i] <= p_in[i];
            for (int i = 0; i < 6; i++) r_d1[i] <= p_in[i+1] - p_in[i];
            for (int i = 0; i < 5; i++) begin
                r_d2[i] <= p_in[i+2] - (p_in[i+1] <<< 1) + p_in[i];
            end
            r_t0 <= (i_t_norm > t_time'(1 << FracW)) ? t_time'(1 << FracW) : i_t_norm;
            r_dur[0] <= i_seg_duration;
            for (int i = 1; i < Lvl + 2; i++) r_dur[i] <= r_dur[i-1];
        end
    end

    // Position triangle: six cells.
    t_val  pa1 [6]; t_val pa2 [5]; t_val pa3 [4]; t_val pa4 [3]; t_val pa5 [2];
    t_val  pa6 [1];
    t_time pt1, pt2, pt3, pt4, pt5, pt6;
    bz6_cell #(.N(7)) u_p1 (.i_clk, .i_en(en), .i_pts(r_p), .i_t(r_t0), .o_pts(pa1), .o_t(pt1));
    bz6_cell #(.N(6)) u_p2 (.i_clk, .i_en(en), .i_pts(pa1), .i_t(pt1), .o_pts(pa2), .o_t(pt2));
    bz6_cell #(.N(5)) u_p3 (.i_clk, .i_en(en), .i_pts(pa2), .i_t(pt2), .o_pts(pa3), .o_t(pt3));
    bz6_cell #(.N(4)) u_p4 (.i_clk, .i_en(en), .i_pts(pa3), .i_t(pt3), .o_pts(pa4), .o_t(pt4));
    bz6_cell #(.N(3)) u_p5 (.i_clk, .i_en(en), .i_pts(pa4), .i_t(pt4), .o_pts(pa5), .o_t(pt5));
    bz6_cell #(.N(2)) u_p6 (.i_clk, .i_en(en), .i_pts(pa5), .i_t(pt5), .o_pts(pa6), .o_t(pt6));

    // Velocity triangle: five cells, then one delay to align.
    t_val va1 [5]; t_val va2 [4]; t_val va3 [3]; t_val va4 [2]; t_val va5 [1];
    t_time vt1, vt2, vt3, vt4, vt5;
    bz6_cell #(.N(6)) u_v1 (.i_clk, .i_en(en), .i_pts(r_d1), .i_t(r_t0), .o_pts(va1), .o_t(vt1));
    bz6_cell #(.N(5)) u_v2 (.i_clk, .i_en(en), .i_pts(va1), .i_t(vt1), .o_pts(va2), .o_t(vt2));
    bz6_cell #(.N(4)) u_v3 (.i_clk, .i_en(en), .i_pts(va2), .i_t(vt2), .o_pts(va3), .o_t(vt3));
    bz6_cell #(.N(3)) u_v4 (.i_clk, .i_en(en), .i_pts(va3), .i_t(vt3), .o_pts(va4), .o_t(vt4));
    bz6_cell #(.N(2)) u_v5 (.i_clk, .i_en(en), .i_pts(va4), .i_t(vt4), .o_pts(va5), .o_t(vt5));

    // Acceleration triangle: four cells, then delays to align.
    t_val aa1 [4]; t_val aa2 [3]; t_val aa3 [2]; t_val aa4 [1];
    t_time at1, at2, at3, at4;
    bz6_cell #(.N(5)) u_a1 (.i_clk, .i_en(en), .i_pts(r_d2), .i_t(r_t0), .o_pts(aa1), .o_t(at1));
    bz6_cell #(.N(4)) u_a2 (.i_clk, .i_en(en), .i_pts(aa1), .i_t(at1), .o_pts(aa2), .o_t(at2));
    bz6_cell #(.N(3)) u_a3 (.i_clk, .i_en(en), .i_pts(aa2), .i_t(at2), .o_pts(aa3), .o_t(at3));
    bz6_cell #(.N(2)) u_a4 (.i_clk, .i_en(en), .i_pts(aa3), .i_t(at3), .o_pts(aa4), .o_t(at4));

    t_val r_bv, r_ba, r_ba2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bv  <= va5[0];
            r_ba  <= aa4[0];
            r_ba2 <= r_ba;
        end
    end

    // Scale stage: position product and velocity times six; acceleration is delayed.
    logic signed [ValW+DurW:0] pos_prod;
    logic signed [ValW+3:0]    vel6;
    logic signed [ValW+DurW:0] r_pos_prod;
    logic signed [ValW+3:0]    r_vel6;
    t_val r_ba3;
    assign pos_prod = pa6[0] * $signed({1'b0, r_dur[Lvl]});
    assign vel6     = ((ValW+4)'(r_bv) <<< 2) + ((ValW+4)'(r_bv) <<< 1);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pos_prod <= pos_prod;
            r_vel6     <= vel6;
            r_ba3      <= r_ba2;
        end
    end

    // Saturate position and velocity; set up the division.
    localparam logic signed [63:0] SMax = 64'sd2147483647;
    localparam logic signed [63:0] SMin = -64'sd2147483648;
    logic signed [63:0] pos_r, vel_w, num;
    logic [QuoW-1:0] mag;
    logic [DataW-1:0] r_pos, r_vel;
    logic r_sat_pv, r_neg, r_zero;
    assign pos_r = (64'(r_pos_prod) + 64'sd128) >>> 8;
    assign vel_w = 64'(r_vel6);
    assign num   = (64'(r_ba3) <<< 13) - (64'(r_ba3) <<< 9);
    assign mag   = num[63] ? QuoW'(-num) : QuoW'(num);

    logic [DurW:0]   dv_rem [DivStages+1];
    logic [QuoW-1:0] dv_num [DivStages+1];
    logic [DurW-1:0] dv_den [DivStages+1];
    logic [DataW-1:0] r_pos_d [DivStages];
    logic [DataW-1:0] r_vel_d [DivStages];
    logic r_sat_d [DivStages];
    logic r_neg_d [DivStages];
    logic r_zero_d [DivStages];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pos <= (pos_r > SMax) ? DataW'(SMax) : (pos_r < SMin) ? DataW'(SMin)
                                                                    : DataW'(pos_r);
            r_vel <= (vel_w > SMax) ? DataW'(SMax) : (vel_w < SMin) ? DataW'(SMin)
                                                                    : DataW'(vel_w);
            r_sat_pv <= (pos_r > SMax) || (pos_r < SMin) || (vel_w > SMax) || (vel_w < SMin);
            r_neg  <= num[63];
            r_zero <= (num == 64'sd0);
            dv_num[0] <= mag + QuoW'(r_dur[Lvl+1] >> 1);
            dv_den[0] <= r_dur[Lvl+1];
            dv_rem[0] <= '0;
            r_pos_d[0] <= r_pos; r_vel_d[0] <= r_vel; r_sat_d[0] <= r_sat_pv;
            r_neg_d[0] <= r_neg; r_zero_d[0] <= r_zero;
            for (int i = 1; i < DivStages; i++) begin
                r_pos_d[i] <= r_pos_d[i-1]; r_vel_d[i] <= r_vel_d[i-1];
                r_sat_d[i] <= r_sat_d[i-1]; r_neg_d[i] <= r_neg_d[i-1];
                r_zero_d[i] <= r_zero_d[i-1];
            end
        end
    end

    // Divider chain: one quotient bit per cell, most significant first.
    for (genvar k = 0; k < DivStages; k++) begin : g_div
        bz6_div_cell #(.QW(QuoW), .DW(DurW), .K(k)) u_dc (
            .i_clk, .i_en(en),
            .i_rem(dv_rem[k]), .i_num(dv_num[k]), .i_den(dv_den[k]),
            .o_rem(dv_rem[k+1]), .o_num(dv_num[k+1]), .o_den(dv_den[k+1])
        );
    end

    // Final result: sign, saturate, and flag. The divider output lines up with the data.
    // A zero numerator gives zero acceleration and never sets the flag.
    logic [QuoW-1:0] q;
    logic signed [63:0] sq;
    logic acc_sat;
    assign q  = dv_num[DivStages];
    assign sq = r_neg_d[DivStages-1] ? -$signed(64'(q)) : $signed(64'(q));
    assign acc_sat = !r_zero_d[DivStages-1] && ((sq > SMax) || (sq < SMin));

    assign o_position     = r_pos_d[DivStages-1];
    assign o_velocity     = r_vel_d[DivStages-1];
    assign o_acceleration = r_zero_d[DivStages-1] ? '0 :
                            (sq > SMax) ? DataW'(SMax) : (sq < SMin) ? DataW'(SMin)
                                                                     : DataW'(sq);
    assign o_saturated    = r_sat_d[DivStages-1] || acc_sat;

    // Checks.
    `BZ_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `BZ_ASSERT_IMP(a_ready, i_clk, i_rst_n, !o_valid, o_ready)
    `BZ_ASSERT_IMP(a_zero, i_clk, i_rst_n, o_valid && r_zero_d[DivStages-1],
                   o_acceleration == '0)
endmodule

// ===== hdl/bz6_cell.sv =====
// One level of the de Casteljau triangle: reduces a row of points by one.
module bz6_cell #(
    parameter int unsigned N = 7
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  bz6_pkg::t_val     i_pts [N],
    input  bz6_pkg::t_time    i_t,
    output bz6_pkg::t_val     o_pts [N-1],
    output bz6_pkg::t_time    o_t
);
    import bz6_pkg::*;

    t_val  r_pts [N-1];
    t_time r_t;

    // Interpolate neighbors and pass time on to the next cell.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < N - 1; i++) begin
                r_pts[i] <= lerp(i_pts[i], i_pts[i+1], i_t);
            end
            r_t <= i_t;
        end
    end

    assign o_pts = r_pts;
    assign o_t   = r_t;
endmodule

// ===== hdl/bz6_div_cell.sv =====
// One restoring division step: produces one quotient bit per cell.
module bz6_div_cell #(
    parameter int unsigned QW = 52,
    parameter int unsigned DW = 16,
    parameter int unsigned K  = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW:0]   i_rem,
    input  logic [QW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [DW:0]   o_rem,
    output logic [QW-1:0] o_num,
    output logic [DW-1:0] o_den
);
    logic [DW+1:0] trial;
    logic [QW-1:0] n_num;
    logic [DW:0]   r_rem;
    logic [QW-1:0] r_num;
    logic [DW-1:0] r_den;

    // Shift in the next dividend bit and try to subtract the divisor.
    // The consumed dividend bit is replaced by the new quotient bit.
    always_comb begin
        trial = {i_rem, i_num[QW-1-K]} - {2'b00, i_den};
        n_num = i_num;
        n_num[QW-1-K] = !trial[DW+1];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!trial[DW+1]) begin
                r_rem <= trial[DW:0];
            end else begin
                r_rem <= {i_rem[DW-1:0], i_num[QW-1-K]};
            end
            r_num <= n_num;
            r_den <= i_den;
        end
    end

    assign o_rem = r_rem;
    assign o_num = r_num;
    assign o_den = r_den;
endmodule

// ===== bench/bezier6_pos_vel_acc_eval_tb.sv =====
module bezier6_pos_vel_acc_eval_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bz6_pkg::*;

    localparam int unsigned NumRandom = 2000;
    localparam int unsigned StallLimit = 3000;
    localparam int unsigned DrainCycles = 100;
    localparam longint QOne = 65536;
    localparam longint S32Max = 64'sd2147483647;
    localparam longint S32Min = -64'sd2147483648;

    typedef struct {
        logic signed [DataW-1:0] pt [NumPts];
        logic [DurW-1:0]         dur;
        logic [TimeW-1:0]        tn;
    } t_sample;

    typedef struct {
        logic signed [DataW-1:0] pos;
        logic signed [DataW-1:0] vel;
        logic signed [DataW-1:0] acc;
        logic                    sat;
    } t_kinematics;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    logic signed [DataW-1:0] pt_drv [NumPts];
    logic [DurW-1:0] i_seg_duration;
    logic [TimeW-1:0] i_t_norm;
    logic o_valid;
    logic i_ready;
    logic signed [DataW-1:0] o_position;
    logic signed [DataW-1:0] o_velocity;
    logic signed [DataW-1:0] o_acceleration;
    logic o_saturated;

    t_sample     pending_samples[$];
    t_sample     sent_samples[$];
    t_kinematics expected_kin[$];
    int unsigned mismatch_count;
    int unsigned quiet_cycles;
    bit          sample_taken;
    bit          kin_taken;
    bit          gaps_on;
    int unsigned send_gap;
    int unsigned recv_stall;
    bit          stim_done;

    bezier6_pos_vel_acc_eval dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_ctrl_point_0 (pt_drv[0]),
        .i_ctrl_point_1 (pt_drv[1]),
        .i_ctrl_point_2 (pt_drv[2]),
        .i_ctrl_point_3 (pt_drv[3]),
        .i_ctrl_point_4 (pt_drv[4]),
        .i_ctrl_point_5 (pt_drv[5]),
        .i_ctrl_point_6 (pt_drv[6]),
        .i_seg_duration (i_seg_duration),
        .i_t_norm       (i_t_norm),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_position     (o_position),
        .o_velocity     (o_velocity),
        .o_acceleration (o_acceleration),
        .o_saturated    (o_saturated)
    );

    // Rounded right shift, ties toward plus infinity.
    function automatic longint shift_round(longint x, int k);
        return (x + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    // Bernstein sum of the first n values by repeated interpolation.
    function automatic longint bernstein_sum(longint v [NumPts], int n, longint t);
        for (int r = n - 1; r > 0; r--) begin
            for (int i = 0; i < r; i++) begin
                v[i] = v[i] + shift_round((v[i + 1] - v[i]) * t, FracW);
            end
        end
        return v[0];
    endfunction

    function automatic longint clip32(longint x, inout bit flag);
        if (x > S32Max) begin
            flag = 1'b1;
            return S32Max;
        end
        if (x < S32Min) begin
            flag = 1'b1;
            return S32Min;
        end
        return x;
    endfunction

    // Position, velocity and acceleration of one curve sample.
    function automatic t_kinematics eval_kinematics(t_sample s);
        longint pts [NumPts];
        longint dif1 [NumPts];
        longint dif2 [NumPts];
        longint t;
        longint d;
        longint bp;
        longint bv;
        longint ba;
        longint num;
        longint mag;
        longint q;
        longint acc;
        bit flag;
        t_kinematics k;
        flag = 1'b0;
        d = longint'(s.dur);
        t = longint'(s.tn);
        if (t > QOne) begin
            t = QOne;
        end
        for (int i = 0; i < NumPts; i++) begin
            pts[i] = longint'(s.pt[i]);
            dif1[i] = 0;
            dif2[i] = 0;
        end
        for (int i = 0; i < 6; i++) begin
            dif1[i] = pts[i + 1] - pts[i];
        end
        for (int i = 0; i < 5; i++) begin
            dif2[i] = dif1[i + 1] - dif1[i];
        end
        bp = bernstein_sum(pts, 7, t);
        bv = bernstein_sum(dif1, 6, t);
        ba = bernstein_sum(dif2, 5, t);
        k.pos = DataW'(clip32(shift_round(bp * d, 8), flag));
        k.vel = DataW'(clip32(bv * 6, flag));
        if (d == 0) begin
            // A zero duration drives acceleration to the limit of its sign.
            if (ba == 0) begin
                acc = 0;
            end else begin
                flag = 1'b1;
                acc = (ba > 0) ? S32Max : S32Min;
            end
        end else begin
            num = ba * 30 * 256;
            mag = (num < 0) ? -num : num;
            q = (mag + d / 2) / d;
            acc = clip32((num < 0) ? -q : q, flag);
        end
        k.acc = DataW'(acc);
        k.sat = flag;
        return k;
    endfunction

    function automatic logic signed [DataW-1:0] rand_point(int mode);
        case (mode)
            0: return $signed($urandom());
            1: return $signed(DataW'($urandom_range(0, 2 * 1048576))) - 1048576;
            2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed(DataW'($urandom_range(0, 2 * 65536 * 200))) - 65536 * 200;
        endcase
    endfunction

    task automatic add_sample(logic signed [DataW-1:0] p0, logic signed [DataW-1:0] p1,
                              logic [DurW-1:0] dur, logic [TimeW-1:0] tn);
        t_sample s;
        for (int i = 0; i < NumPts; i++) begin
            s.pt[i] = (i % 2 == 0) ? p0 : p1;
        end
        s.dur = dur;
        s.tn = tn;
        pending_samples.insert(pending_samples.size(), s);
    endtask

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Stimulus: directed corners first, then random curves.
    initial begin
        t_sample s;
        int mode;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        for (int i = 0; i < NumPts; i++) begin
            pt_drv[i] = '0;
        end
        i_seg_duration = '0;
        i_t_norm = '0;
        mismatch_count = 0;
        stim_done = 1'b0;
        gaps_on = 1'b0;

        add_sample(32'sd0, 32'sd0, 16'd256, 17'd0);
        add_sample(32'sh7fffffff, 32'sh7fffffff, 16'hffff, 17'd65536);
        add_sample(32'sh80000000, 32'sh80000000, 16'hffff, 17'd32768);
        add_sample(32'sh7fffffff, 32'sh80000000, 16'd1, 17'd0);
        add_sample(32'sh80000000, 32'sh7fffffff, 16'd1, 17'd65536);
        add_sample(32'sh7fffffff, 32'sh80000000, 16'hffff, 17'd32768);
        add_sample(32'sh80000000, 32'sh7fffffff, 16'd256, 17'd1);
        add_sample(32'sd1, -32'sd1, 16'd256, 17'd32768);
        add_sample(-32'sd1, 32'sd1, 16'd3, 17'd65535);
        add_sample(32'sd65536, 32'sd0, 16'd128, 17'd16384);
        add_sample(32'sh55555555, 32'shaaaaaaaa, 16'h5555, 17'h0aaaa);
        add_sample(32'shaaaaaaaa, 32'sh55555555, 16'haaaa, 17'h15555);
        // Zero duration, with and without curvature.
        add_sample(32'sd65536, 32'sd65536, 16'd0, 17'd32768);
        add_sample(32'sd65536, -32'sd65536, 16'd0, 17'd16384);
        for (int n = 0; n < 6; n++) begin
            for (int i = 0; i < NumPts; i++) begin
                s.pt[i] = 32'sd65536 * i;
            end
            s.pt[n] = (n % 2) ? 32'sh80000000 : 32'sh7fffffff;
            s.dur = DurW'($urandom_range(1, 65535));
            s.tn = TimeW'($urandom_range(0, 65536));
            pending_samples.insert(pending_samples.size(), s);
        end

        for (int n = 0; n < NumRandom; n++) begin
            // Mostly smooth curves of moderate size, some at full range.
            mode = $urandom_range(0, 9);
            mode = (mode < 5) ? 3 : (mode < 7) ? 1 : (mode < 9) ? 0 : 2;
            for (int i = 0; i < NumPts; i++) begin
                s.pt[i] = ($urandom_range(0, 7) == 0) ? rand_point($urandom_range(0, 3))
                                                      : rand_point(mode);
            end
            case ($urandom_range(0, 5))
                0: s.dur = DurW'($urandom_range(1, 8));
                1: s.dur = 16'hffff - DurW'($urandom_range(0, 8));
                default: s.dur = DurW'($urandom_range(1, 65535));
            endcase
            case ($urandom_range(0, 7))
                0: s.tn = 17'd0;
                1: s.tn = 17'd65536;
                default: s.tn = TimeW'($urandom_range(0, 65536));
            endcase
            pending_samples.insert(pending_samples.size(), s);
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_samples.size() == 0 && !i_valid && expected_kin.size() == 0);
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Record transfers on both channels and check results.
    always @(posedge i_clk) begin
        t_kinematics exp_k;
        sample_taken = i_rst_n && i_valid && o_ready;
        kin_taken = i_rst_n && o_valid && i_ready;
        if (sample_taken) begin
            expected_kin.insert(expected_kin.size(),
                                eval_kinematics(sent_samples.pop_front()));
        end
        if (kin_taken) begin
            if (expected_kin.size() == 0) begin
                $error("result transfer with no expected result");
                mismatch_count++;
            end else begin
                exp_k = expected_kin.pop_front();
                if (o_position !== exp_k.pos) begin
                    $error("position: expected %0d, got %0d", exp_k.pos, o_position);
                    mismatch_count++;
                end
                if (o_velocity !== exp_k.vel) begin
                    $error("velocity: expected %0d, got %0d", exp_k.vel, o_velocity);
                    mismatch_count++;
                end
                if (o_acceleration !== exp_k.acc) begin
                    $error("acceleration: expected %0d, got %0d", exp_k.acc, o_acceleration);
                    mismatch_count++;
                end
                if (o_saturated !== exp_k.sat) begin
                    $error("saturated: expected %0b, got %0b", exp_k.sat, o_saturated);
                    mismatch_count++;
                end
            end
        end
        // Watchdog on cycles without any transfer.
        if (!i_rst_n || sample_taken || kin_taken) begin
            quiet_cycles = 0;
        end else if (i_valid || expected_kin.size() != 0) begin
            quiet_cycles++;
            if (quiet_cycles >= StallLimit) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Sample driver and result acceptor, both moving on the falling edge.
    always @(negedge i_clk) begin
        t_sample s;
        if (i_rst_n) begin
            // At random, with odds of one in 200, switch idling on or off.
            if ($urandom_range(0, 199) == 0) begin
                gaps_on = !gaps_on;
            end
            if (sample_taken) begin
                send_gap = gaps_on ? $urandom_range(0, 16) : 0;
            end
            if (!i_valid || sample_taken) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_samples.size() != 0) begin
                    s = pending_samples.pop_front();
                    sent_samples.insert(sent_samples.size(), s);
                    for (int i = 0; i < NumPts; i++) begin
                        pt_drv[i] <= s.pt[i];
                    end
                    i_seg_duration <= s.dur;
                    i_t_norm <= s.tn;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            if (kin_taken) begin
                recv_stall = gaps_on ? $urandom_range(0, 16) : 0;
            end
            if (recv_stall > 0) begin
                recv_stall--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

endmodule

// ===== bezier6_pos_vel_acc_eval.f =====
+incdir+hdl
hdl/bz6_pkg.sv
hdl/bz6_cell.sv
hdl/bz6_div_cell.sv
hdl/bezier6_pos_vel_acc_eval.sv
bench/bezier6_pos_vel_acc_eval_tb.sv
